/* sv/dpp_pkg.sv */
// shared types, constants and codes of the dependency priority picker
`timescale 1ns / 1ps

package dpp_pkg;

  // table size default and fixed field widths
  localparam int unsigned MAX_NODES_DEF = 16;
  localparam int unsigned NODE_W        = 4;
  localparam int unsigned MASK_W        = 16;
  localparam int unsigned PRIO_W        = 32;
  localparam int unsigned DL_W          = 64;
  localparam int unsigned NIU_W         = 5;
  localparam int unsigned WIN_W         = 16;
  localparam int unsigned AMT_W         = 16;
  localparam int unsigned CFG_ADDR_W    = 2;
  localparam int unsigned CFG_DATA_W    = 16;
  // effective priority: signed base plus unsigned boost, never wraps
  localparam int unsigned EFF_W         = 34;

  // reset values of the configuration registers
  localparam logic [NIU_W-1:0] NIU_RST = NIU_W'(16);
  localparam logic [WIN_W-1:0] WIN_RST = WIN_W'(100);
  localparam logic [AMT_W-1:0] AMT_RST = AMT_W'(1000);

  // deadline value that means no deadline
  localparam logic [DL_W-1:0] NO_DEADLINE = {DL_W{1'b1}};

  // lowest base priority, widened; a pick must beat it strictly
  localparam logic signed [EFF_W-1:0] EFF_FLOOR =
    {{(EFF_W-PRIO_W){1'b1}}, 1'b1, {(PRIO_W-1){1'b0}}};

  // operation codes of an item
  typedef enum logic [2:0] {
    MODE_PRED     = 3'd0,
    MODE_PRIO     = 3'd1,
    MODE_DEADLINE = 3'd2,
    MODE_PICK     = 3'd3,
    MODE_RESTART  = 3'd4
  } dpp_mode_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_NO_READY = 2'd2
  } dpp_status_e;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NODES  = 2'd0,
    REG_WINDOW = 2'd1,
    REG_AMOUNT = 2'd2
  } dpp_cfg_e;

  // table write command to one cell
  typedef struct packed {
    logic                     set_pred;
    logic                     set_prio;
    logic                     set_dl;
    logic [MASK_W-1:0]        mask;
    logic signed [PRIO_W-1:0] prio;
    logic [DL_W-1:0]          deadline;
  } dpp_wr_t;

  // values broadcast to every cell
  typedef struct packed {
    logic [DL_W-1:0]   cycle;
    logic [WIN_W-1:0]  window;
    logic [AMT_W-1:0]  amount;
    logic [MASK_W-1:0] pend;
  } dpp_env_t;

  // best candidate so far, handed along the chain
  typedef struct packed {
    logic                    valid;
    logic                    missed;
    logic signed [EFF_W-1:0] prio;
  } dpp_cand_t;

endpackage

/* sv/dpp_cell.sv */
// one table entry of the picker with its stage of the candidate chain
`timescale 1ns / 1ps

module dpp_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned IDX   = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpp_pkg::dpp_wr_t   wr_i,
  input  logic               set_done_i,
  input  logic               clr_done_i,
  input  logic               active_i,
  input  dpp_pkg::dpp_env_t  env_i,
  input  dpp_pkg::dpp_cand_t cand_i,
  input  logic [IDX_W-1:0]   idx_i,
  output dpp_pkg::dpp_cand_t cand_o,
  output logic [IDX_W-1:0]   idx_o,
  output logic               done_o
);
  import dpp_pkg::*;

  logic [MASK_W-1:0]        pred_q;
  logic signed [PRIO_W-1:0] prio_q;
  logic [DL_W-1:0]          dl_q;
  logic                     done_q;

  logic                     elig_q, elig_d;
  logic                     missed_q, missed_d;
  logic signed [EFF_W-1:0]  eff_q, eff_d;
  dpp_cand_t                cand_q, cand_d;
  logic [IDX_W-1:0]         idx_q, idx_d;

  logic                     has_dl;
  logic [DL_W-1:0]          gap;
  logic                     near;
  logic [EFF_W-1:0]         boost_add;
  logic                     take;

  // entry storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q <= '0;
      prio_q <= '0;
      dl_q   <= NO_DEADLINE;
      done_q <= 1'b0;
    end else begin
      if (wr_i.set_pred) begin
        pred_q <= wr_i.mask;
      end
      if (wr_i.set_prio) begin
        prio_q <= wr_i.prio;
      end
      if (wr_i.set_dl) begin
        dl_q <= wr_i.deadline;
      end
      if (clr_done_i) begin
        done_q <= 1'b0;
      end else if (set_done_i) begin
        done_q <= 1'b1;
      end
    end
  end

  // readiness, deadline boost and missed deadline of this entry
  always_comb begin
    has_dl    = (dl_q != NO_DEADLINE);
    gap       = dl_q - env_i.cycle;
    near      = has_dl && (gap < DL_W'(env_i.window));
    boost_add = near ? {{(EFF_W-AMT_W){1'b0}}, env_i.amount} : '0;
    eff_d     = EFF_W'(prio_q) + $signed(boost_add);
    missed_d  = has_dl && (env_i.cycle > dl_q);
    elig_d    = active_i && !done_q && ((pred_q & env_i.pend) == '0);
  end

  // compare against the incoming candidate, ties keep the lower index
  always_comb begin
    take   = elig_q && (eff_q > $signed(cand_i.prio));
    cand_d = cand_i;
    idx_d  = idx_i;
    if (take) begin
      cand_d.valid  = 1'b1;
      cand_d.missed = missed_q;
      cand_d.prio   = eff_q;
      idx_d         = IDX_W'(IDX);
    end
  end

  // chain stage and local scores
  always_ff @(posedge clk_i) begin
    elig_q   <= elig_d;
    missed_q <= missed_d;
    eff_q    <= eff_d;
    cand_q   <= cand_d;
    idx_q    <= idx_d;
  end

  assign cand_o = cand_q;
  assign idx_o  = idx_q;
  assign done_o = done_q;

endmodule

/* sv/dependency_priority_picker.sv */
// Dependency priority picker: a pick sends the best candidate along a chain of MAX_NODES cells,
// one cell per cycle. A pick holds the block busy through the scan and finish states; its result
// strobe is registered from the finish state, and the next item is accepted only back in idle.
// Table writes, restart and unused modes give their result in the cycle after acceptance and
// another item can be accepted at once. Reset is asynchronous: all tables, done flags, the cycle
// counter and configuration take their reset values at once. Results cannot be stalled.
`timescale 1ns / 1ps

module dependency_priority_picker #(
  parameter int unsigned MAX_NODES = dpp_pkg::MAX_NODES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [2:0]                           mode_i,
  input  logic [dpp_pkg::NODE_W-1:0]           node_i,
  input  logic [dpp_pkg::MASK_W-1:0]           dep_mask_i,
  input  logic signed [dpp_pkg::PRIO_W-1:0]    priority_req_i,
  input  logic [dpp_pkg::DL_W-1:0]             deadline_i,
  input  logic                                 cfg_we_i,
  input  logic [dpp_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [dpp_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  output logic                                 valid_o,
  output logic [1:0]                           status_o,
  output logic [dpp_pkg::NODE_W-1:0]           picked_node_o,
  output logic                                 deadline_missed_o,
  output logic [dpp_pkg::DL_W-1:0]             pick_cycle_o
);
  import dpp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned CMP_W = (CNT_W > NIU_W) ? CNT_W : NIU_W;
  localparam int unsigned NODE_SPAN = 2 ** NODE_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } dpp_state_e;

  dpp_state_e        state_q, state_d;
  logic [IDX_W-1:0]  scan_q, scan_d;
  logic [DL_W-1:0]   cycle_q, cycle_d;
  logic [NIU_W-1:0]  nodes_q;
  logic [WIN_W-1:0]  window_q;
  logic [AMT_W-1:0]  amount_q;

  logic              valid_q, valid_d;
  dpp_status_e       status_q, status_d;
  logic [NODE_W-1:0] picked_q, picked_d;
  logic              missed_q, missed_d;
  logic [DL_W-1:0]   pcycle_q, pcycle_d;

  logic              accept;
  logic [CMP_W-1:0]  count;
  logic              node_ok;
  logic              wr_pred, wr_prio, wr_dl, restart;
  logic              fin_hit;
  dpp_env_t          env;

  logic [MAX_NODES-1:0] done_vec;
  logic [MAX_NODES-1:0] active;
  dpp_cand_t            cand   [MAX_NODES+1];
  logic [IDX_W-1:0]     cidx   [MAX_NODES+1];

  // handshake and active count
  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign count   = (CMP_W'(nodes_q) > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : CMP_W'(nodes_q);
  assign node_ok = (CMP_W'(node_i) < count);

  // item decode
  always_comb begin
    wr_pred = 1'b0;
    wr_prio = 1'b0;
    wr_dl   = 1'b0;
    restart = 1'b0;
    case (dpp_mode_e'(mode_i))
      MODE_PRED:     wr_pred = accept && node_ok;
      MODE_PRIO:     wr_prio = accept && node_ok;
      MODE_DEADLINE: wr_dl   = accept && node_ok;
      MODE_RESTART:  restart = accept;
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q  <= NIU_RST;
      window_q <= WIN_RST;
      amount_q <= AMT_RST;
    end else if (cfg_we_i) begin
      case (dpp_cfg_e'(cfg_addr_i))
        REG_NODES:  nodes_q  <= cfg_wdata_i[NIU_W-1:0];
        REG_WINDOW: window_q <= cfg_wdata_i[WIN_W-1:0];
        REG_AMOUNT: amount_q <= cfg_wdata_i[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  // pending predecessors: in range and not yet done
  always_comb begin
    env.cycle  = cycle_q;
    env.window = window_q;
    env.amount = amount_q;
    for (int j = 0; j < MASK_W; j++) begin
      if (j < MAX_NODES) begin
        env.pend[j] = (CMP_W'(j) < count) && !done_vec[j];
      end else begin
        env.pend[j] = 1'b0;
      end
    end
  end

  // chain head: no candidate yet
  assign cand[0].valid  = 1'b0;
  assign cand[0].missed = 1'b0;
  assign cand[0].prio   = EFF_FLOOR;
  assign cidx[0]        = '0;

  assign fin_hit = (state_q == ST_FIN) && cand[MAX_NODES].valid;

  // row of cells
  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    dpp_wr_t wr;
    logic    sel;
    logic    set_done;

    if (i < NODE_SPAN) begin : g_addr
      assign sel = (node_i == NODE_W'(i));
    end else begin : g_noaddr
      assign sel = 1'b0;
    end

    assign wr.set_pred = wr_pred && sel;
    assign wr.set_prio = wr_prio && sel;
    assign wr.set_dl   = wr_dl && sel;
    assign wr.mask     = dep_mask_i;
    assign wr.prio     = priority_req_i;
    assign wr.deadline = deadline_i;
    assign active[i]   = (CMP_W'(i) < count);
    assign set_done    = fin_hit && (cidx[MAX_NODES] == IDX_W'(i));

    dpp_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_i       (wr),
      .set_done_i (set_done),
      .clr_done_i (restart),
      .active_i   (active[i]),
      .env_i      (env),
      .cand_i     (cand[i]),
      .idx_i      (cidx[i]),
      .cand_o     (cand[i+1]),
      .idx_o      (cidx[i+1]),
      .done_o     (done_vec[i])
    );
  end

  // sequencer and cycle counter
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    cycle_d = cycle_q;
    case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        if (accept && (dpp_mode_e'(mode_i) == MODE_PICK)) begin
          state_d = ST_SCAN;
        end
        if (restart) begin
          cycle_d = '0;
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + IDX_W'(1);
        if (scan_q == IDX_W'(MAX_NODES - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
        if (cand[MAX_NODES].valid) begin
          cycle_d = cycle_q + DL_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result of the current item
  always_comb begin
    valid_d  = 1'b0;
    status_d = STATUS_OK;
    picked_d = '0;
    missed_d = 1'b0;
    pcycle_d = '0;
    if (state_q == ST_FIN) begin
      valid_d = 1'b1;
      if (cand[MAX_NODES].valid) begin
        picked_d = NODE_W'(cidx[MAX_NODES]);
        missed_d = cand[MAX_NODES].missed;
        pcycle_d = cycle_q;
      end else begin
        status_d = STATUS_NO_READY;
      end
    end else if (accept && (dpp_mode_e'(mode_i) != MODE_PICK)) begin
      valid_d = 1'b1;
      case (dpp_mode_e'(mode_i))
        MODE_PRED, MODE_PRIO, MODE_DEADLINE: begin
          status_d = node_ok ? STATUS_OK : STATUS_RANGE;
        end
        default: status_d = STATUS_OK;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= '0;
      cycle_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      cycle_q <= cycle_d;
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    picked_q <= picked_d;
    missed_q <= missed_d;
    pcycle_q <= pcycle_d;
  end

  assign valid_o           = valid_q;
  assign status_o          = status_q;
  assign picked_node_o     = picked_q;
  assign deadline_missed_o = missed_q;
  assign pick_cycle_o      = pcycle_q;

  // a strobe follows either a finished scan or an accepted item that is not a pick
  a_strobe_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q == ST_FIN) ||
                 $past(accept && (dpp_mode_e'(mode_i) != MODE_PICK))))
    else $error("result strobe without a finished item");

  // an accepted pick occupies the block
  a_pick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (dpp_mode_e'(mode_i) == MODE_PICK)) |=> busy_o)
    else $error("pick accepted but block not busy");

  // a successful pick advances the cycle counter by one
  a_cycle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_hit |=> (cycle_q == $past(cycle_q) + DL_W'(1)))
    else $error("cycle counter not advanced after pick");

  // a failed pick reports nothing else
  a_no_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == STATUS_NO_READY)) |->
      ((picked_node_o == '0) && !deadline_missed_o && (pick_cycle_o == '0)))
    else $error("no-ready result carries pick data");

endmodule

/* tb/dpp_schedule_checker.sv */
// checker of the dependency priority picker: tracks the node table, predicts every result
`timescale 1ns / 1ps

module dpp_schedule_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic [2:0]                        mode_i,
  input  logic [dpp_pkg::NODE_W-1:0]        node_i,
  input  logic [dpp_pkg::MASK_W-1:0]        dep_mask_i,
  input  logic signed [dpp_pkg::PRIO_W-1:0] priority_req_i,
  input  logic [dpp_pkg::DL_W-1:0]          deadline_i,
  input  logic                              cfg_we_i,
  input  logic [dpp_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [dpp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              valid_i,
  input  logic [1:0]                        status_i,
  input  logic [dpp_pkg::NODE_W-1:0]        picked_node_i,
  input  logic                              deadline_missed_i,
  input  logic [dpp_pkg::DL_W-1:0]          pick_cycle_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import dpp_pkg::*;

  localparam int unsigned NODES = MAX_NODES_DEF;

  // one result item as the block should report it
  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] node;
    logic              missed;
    logic [DL_W-1:0]   cycle;
  } outcome_t;

  // shadow copy of the node table, counter and registers
  logic signed [PRIO_W-1:0] prio_tab [NODES];
  logic [DL_W-1:0]          dl_tab   [NODES];
  logic [MASK_W-1:0]        pred_tab [NODES];
  logic [NODES-1:0]         done_flags;
  logic [DL_W-1:0]          cycle_cnt;
  logic [NIU_W-1:0]         nodes_cfg;
  logic [WIN_W-1:0]         window_cfg;
  logic [AMT_W-1:0]         amount_cfg;

  outcome_t awaited_results[$];
  outcome_t head;
  int       fail_cnt = 0;

  assign fail_count_o = fail_cnt;

  task automatic report_failure(input string what);
    fail_cnt++;
    $display("%0t: %s", $time, what);
  endtask

  // apply one item to the shadow table and return what the block must answer
  function automatic outcome_t schedule_outcome(input logic [2:0] mode,
                                                input logic [NODE_W-1:0] node,
                                                input logic [MASK_W-1:0] mask,
                                                input logic signed [PRIO_W-1:0] prio,
                                                input logic [DL_W-1:0] deadline);
    outcome_t    res;
    int unsigned cnt;
    logic        found;
    logic        ready;
    int unsigned best;
    longint      best_eff;
    longint      eff;
    res = '0;
    cnt = (nodes_cfg > NODES) ? NODES : nodes_cfg;
    case (mode)
      MODE_PRED, MODE_PRIO, MODE_DEADLINE: begin
        if (node >= cnt) begin
          res.status = STATUS_RANGE;
        end else if (mode == MODE_PRED) begin
          pred_tab[node] = mask;
        end else if (mode == MODE_PRIO) begin
          prio_tab[node] = prio;
        end else begin
          dl_tab[node] = deadline;
        end
      end
      MODE_PICK: begin
        found    = 1'b0;
        best     = 0;
        best_eff = -64'sd2147483648;
        for (int i = 0; i < cnt; i++) begin
          // ready: not done and every in-range predecessor done
          ready = !done_flags[i];
          for (int j = 0; j < cnt; j++) begin
            if (pred_tab[i][j] && !done_flags[j]) ready = 1'b0;
          end
          if (ready) begin
            eff = prio_tab[i];
            if (dl_tab[i] != NO_DEADLINE && (dl_tab[i] - cycle_cnt) < {48'd0, window_cfg}) begin
              eff = eff + longint'({48'd0, amount_cfg});
            end
            if (eff > best_eff) begin
              best_eff = eff;
              best     = i;
              found    = 1'b1;
            end
          end
        end
        if (!found) begin
          res.status = STATUS_NO_READY;
        end else begin
          res.node   = NODE_W'(best);
          res.cycle  = cycle_cnt;
          res.missed = (dl_tab[best] != NO_DEADLINE) && (cycle_cnt > dl_tab[best]);
          done_flags[best] = 1'b1;
          cycle_cnt = cycle_cnt + 64'd1;
        end
      end
      MODE_RESTART: begin
        done_flags = '0;
        cycle_cnt  = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // results first, then register writes, then the newly accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        prio_tab[i] = '0;
        dl_tab[i]   = NO_DEADLINE;
        pred_tab[i] = '0;
      end
      done_flags = '0;
      cycle_cnt  = '0;
      nodes_cfg  = NIU_RST;
      window_cfg = WIN_RST;
      amount_cfg = AMT_RST;
      awaited_results.delete();
    end else begin
      if (valid_i) begin
        if (awaited_results.size() == 0) begin
          report_failure("result with no item pending");
        end else begin
          head = awaited_results.pop_front();
          if (status_i !== head.status)
            report_failure($sformatf("status %0d, expected %0d", status_i, head.status));
          if (picked_node_i !== head.node)
            report_failure($sformatf("picked node %0d, expected %0d", picked_node_i,
                                     head.node));
          if (deadline_missed_i !== head.missed)
            report_failure($sformatf("deadline missed %0b, expected %0b", deadline_missed_i,
                                     head.missed));
          if (pick_cycle_i !== head.cycle)
            report_failure($sformatf("pick cycle %0h, expected %0h", pick_cycle_i,
                                     head.cycle));
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_NODES:  nodes_cfg  = cfg_wdata_i[NIU_W-1:0];
          REG_WINDOW: window_cfg = cfg_wdata_i[WIN_W-1:0];
          REG_AMOUNT: amount_cfg = cfg_wdata_i[AMT_W-1:0];
          default: begin
          end
        endcase
      end
      if (start_i && !busy_i) begin
        awaited_results.push_back(schedule_outcome(mode_i, node_i, dep_mask_i,
                                                   priority_req_i, deadline_i));
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

/* tb/dependency_priority_picker_tb.sv */
// testbench top of the dependency priority picker: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module dependency_priority_picker_tb;
  import dpp_pkg::*;

  localparam int unsigned NODES = MAX_NODES_DEF;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [2:0]               mode;
  logic [NODE_W-1:0]        node;
  logic [MASK_W-1:0]        dep_mask;
  logic signed [PRIO_W-1:0] prio_req;
  logic [DL_W-1:0]          deadline;
  logic                     cfg_we;
  logic [CFG_ADDR_W-1:0]    cfg_addr;
  logic [CFG_DATA_W-1:0]    cfg_wdata;
  logic                     res_valid;
  logic [1:0]               status;
  logic [NODE_W-1:0]        picked_node;
  logic                     deadline_missed;
  logic [DL_W-1:0]          pick_cycle;
  int                       fail_count;
  int                       pending;
  int unsigned              cur_cnt;

  dependency_priority_picker #(
    .MAX_NODES(NODES)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .mode_i           (mode),
    .node_i           (node),
    .dep_mask_i       (dep_mask),
    .priority_req_i   (prio_req),
    .deadline_i       (deadline),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata),
    .valid_o          (res_valid),
    .status_o         (status),
    .picked_node_o    (picked_node),
    .deadline_missed_o(deadline_missed),
    .pick_cycle_o     (pick_cycle)
  );

  dpp_schedule_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .mode_i           (mode),
    .node_i           (node),
    .dep_mask_i       (dep_mask),
    .priority_req_i   (prio_req),
    .deadline_i       (deadline),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata),
    .valid_i          (res_valid),
    .status_i         (status),
    .picked_node_i    (picked_node),
    .deadline_missed_i(deadline_missed),
    .pick_cycle_i     (pick_cycle),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // present one item and hold it until the block takes it
  task automatic issue(input logic [2:0] m, input logic [NODE_W-1:0] n,
                       input logic [MASK_W-1:0] msk, input logic [PRIO_W-1:0] p,
                       input logic [DL_W-1:0] dl);
    start    <= 1'b1;
    mode     <= m;
    node     <= n;
    dep_mask <= msk;
    prio_req <= p;
    deadline <= dl;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending until every pending result has come and the block is free
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
  endtask

  // write all three registers, block idle; spare bits above the node count are noise
  task automatic configure(input logic [NIU_W-1:0] niu, input logic [WIN_W-1:0] win,
                           input logic [AMT_W-1:0] amt);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_NODES;
    cfg_wdata <= {11'($urandom), niu};
    @(posedge clk);
    cfg_addr  <= REG_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_addr  <= REG_AMOUNT;
    cfg_wdata <= amt;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cnt = (niu > NODES) ? NODES : niu;
  endtask

  // random item biased toward mostly-valid nodes, acyclic masks and near deadlines
  task automatic random_item();
    logic [2:0]        m;
    logic [NODE_W-1:0] n;
    logic [MASK_W-1:0] msk;
    logic [PRIO_W-1:0] p;
    logic [DL_W-1:0]   dl;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if (r < 14) m = MODE_PRED;
    else if (r < 30) m = MODE_PRIO;
    else if (r < 44) m = MODE_DEADLINE;
    else if (r < 86) m = MODE_PICK;
    else if (r < 93) m = MODE_RESTART;
    else m = 3'($urandom_range(5, 7));
    if (cur_cnt == 0 || $urandom_range(0, 9) == 0) n = NODE_W'($urandom_range(0, 15));
    else n = NODE_W'($urandom_range(0, cur_cnt - 1));
    case ($urandom_range(0, 3))
      0: msk = '0;
      1: msk = MASK_W'($urandom);
      default: msk = MASK_W'($urandom & $urandom) & ((16'd1 << n) - 16'd1);
    endcase
    case ($urandom_range(0, 4))
      0: p = $urandom;
      1: p = 32'($urandom_range(0, 6)) - 32'd3;
      2: p = 32'h8000_0000 + 32'($urandom_range(0, 2));
      3: p = 32'h8000_0000 + 32'($urandom_range(0, 70000));
      default: p = 32'h7fff_ffff - 32'($urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 4))
      0: dl = NO_DEADLINE;
      1, 2: dl = 64'($urandom_range(0, 40));
      3: dl = {$urandom, $urandom};
      default: dl = NO_DEADLINE - 64'($urandom_range(1, 40));
    endcase
    issue(m, n, msk, p, dl);
  endtask

  // stimulus
  initial begin
    logic [NIU_W-1:0] niu;
    logic [WIN_W-1:0] win;
    logic [AMT_W-1:0] amt;
    logic             quiet;
    rst_n     = 1'b0;
    start     = 1'b0;
    mode      = '0;
    node      = '0;
    dep_mask  = '0;
    prio_req  = '0;
    deadline  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    cur_cnt   = NODES;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, ties, extreme priorities, boost and missed deadline
    issue(MODE_PICK, 4'd0, '0, '0, '0);
    issue(MODE_PRIO, 4'd15, '0, 32'h7fff_ffff, '0);
    issue(MODE_PICK, 4'd0, '0, '0, '0);
    issue(MODE_PRIO, 4'd3, '0, 32'h8000_0000, '0);
    issue(MODE_DEADLINE, 4'd3, '0, '0, 64'd5);
    issue(MODE_PRED, 4'd1, 16'hffff, '0, '0);
    issue(MODE_PRED, 4'd2, 16'h0008, '0, '0);
    issue(MODE_PICK, 4'd0, '0, '0, '0);
    issue(MODE_DEADLINE, 4'd7, '0, '0, 64'd0);
    issue(MODE_PRIO, 4'd7, '0, 32'd1, '0);
    issue(MODE_PICK, 4'd0, '0, '0, '0);
    issue(MODE_DEADLINE, 4'd9, '0, '0, NO_DEADLINE);
    issue(3'd5, 4'd0, '0, '0, '0);
    issue(3'd6, 4'd0, '0, '0, '0);
    issue(3'd7, 4'd0, '0, '0, '0);
    issue(MODE_RESTART, 4'd0, '0, '0, '0);

    // shrunk count: out-of-range writes, high mask bits ignored, nothing ready
    drain();
    configure(5'd4, 16'd0, 16'd0);
    issue(MODE_PRIO, 4'd4, '0, 32'd9, '0);
    issue(MODE_PRED, 4'd5, 16'h0001, '0, '0);
    issue(MODE_DEADLINE, 4'd15, '0, '0, 64'd3);
    issue(MODE_PRED, 4'd0, 16'hfff0, '0, '0);
    issue(MODE_PICK, 4'd0, '0, '0, '0);
    issue(MODE_PICK, 4'd0, '0, '0, '0);

    // zero count, then a count above the table size
    drain();
    configure(5'd0, 16'hffff, 16'hffff);
    issue(MODE_PICK, 4'd0, '0, '0, '0);
    issue(MODE_PRIO, 4'd0, '0, 32'd5, '0);
    drain();
    configure(5'd31, 16'hffff, 16'hffff);
    issue(MODE_PICK, 4'd0, '0, '0, '0);
    issue(MODE_PICK, 4'd0, '0, '0, '0);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case ($urandom_range(0, 5))
        0: niu = 5'd16;
        1: niu = 5'd1;
        2: niu = 5'd2;
        3: niu = 5'($urandom_range(0, 31));
        default: niu = 5'($urandom_range(3, 16));
      endcase
      case ($urandom_range(0, 4))
        0: win = '0;
        1: win = 16'hffff;
        2: win = WIN_W'($urandom);
        default: win = WIN_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 3))
        0: amt = '0;
        1: amt = 16'hffff;
        default: amt = AMT_W'($urandom);
      endcase
      if (ph == 0) begin
        win = 16'hffff;
        amt = 16'hffff;
      end else if (ph == 1) begin
        niu = 5'd1;
        win = '0;
        amt = '0;
      end else if (ph == 7) begin
        niu = 5'd16;
      end
      configure(niu, win, amt);
      quiet = (ph == 7) || ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 118; k++) begin
        if ($urandom_range(0, 59) == 0) drain();
        random_item();
        if (!quiet && $urandom_range(0, 2) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end

    // let the last results arrive, then a short tail for strays
    drain();
    repeat (NODES + 4) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
